FILE: design/text_console_cell_writer_assert.svh
// Assertion macros shared by the text console checker.
// Plain text macros only; no other dependencies.
`ifndef TEXT_CONSOLE_CELL_WRITER_ASSERT_SVH
`define TEXT_CONSOLE_CELL_WRITER_ASSERT_SVH

// Same-cycle implication, disabled while reset is low.
`define TCCW_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("%m: same-cycle check failed");

// Next-cycle implication, disabled while reset is low.
`define TCCW_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("%m: next-cycle check failed");

`endif

FILE: design/tccw_pkg.sv
// Shared constants for the text console cell writer.
// Used by the top level and its port checker; no dependencies.
`timescale 1ns / 1ps
`default_nettype none

package tccw_pkg;

  localparam int DEF_MAX_COLS = 128;
  localparam int DEF_MAX_ROWS = 96;

  localparam int COL_W  = 8;
  localparam int ROW_W  = 7;
  localparam int CHAR_W = 8;
  localparam int RCOL_W = 7;

  // Input word: char_code, read_row, read_col, zero fill.
  localparam int IN_TDATA_W   = 24;
  localparam int IN_CODE_LSB  = 0;
  localparam int IN_RROW_LSB  = 8;
  localparam int IN_RCOL_LSB  = 15;

  // Result word: cursor_col, cursor_row, stored, scrolled, read_char, zero fill.
  localparam int OUT_TDATA_W   = 32;
  localparam int OUT_COL_LSB   = 0;
  localparam int OUT_ROW_LSB   = 8;
  localparam int OUT_STORED_BIT = 15;
  localparam int OUT_SCROLL_BIT = 16;
  localparam int OUT_CHAR_LSB  = 17;
  localparam int OUT_USED_W    = 25;

  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 8;
  localparam logic [CFG_IDX_W-1:0] CFG_COLUMNS = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_ROWS    = 1'b1;

  localparam logic [COL_W-1:0] COLUMNS_RST = 8'd127;
  localparam logic [ROW_W-1:0] ROWS_RST    = 7'd95;

  localparam logic KIND_PUT  = 1'b0;
  localparam logic KIND_READ = 1'b1;

  localparam logic [CHAR_W-1:0] CODE_TAB = 8'd9;
  localparam logic [CHAR_W-1:0] CODE_LF  = 8'd10;
  localparam logic [CHAR_W-1:0] CODE_CR  = 8'd13;

  // Tab stops every five columns; x / 5 == (x * 205) >> 10 for x below 1024.
  localparam int TAB_STOP     = 5;
  localparam int TAB_RECIP    = 205;
  localparam int TAB_RECIP_SH = 10;
  localparam int TAB_QUOT_W   = 6;

endpackage

`default_nettype wire

FILE: design/tccw_cell_ram.sv
// Character cell memory: one write port, one read port with registered data.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module tccw_cell_ram #(
  parameter int DEPTH = 12288,
  parameter int AW    = 14,
  parameter int DW    = 8
) (
  input  wire logic          clk,
  input  wire logic          we,
  input  wire logic [AW-1:0] waddr,
  input  wire logic [DW-1:0] wdata,
  input  wire logic          re,
  input  wire logic [AW-1:0] raddr,
  output logic      [DW-1:0] rdata
);

  logic [DW-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

FILE: design/text_console_cell_writer.sv
// Text console cell writer: top level with the cursor sequencer and address unit.
// Depends on tccw_pkg and tccw_cell_ram.
//
//   channel  | direction | handshake            | payload
//   ---------+-----------+----------------------+--------------------------------------
//   in_      | in        | in_tvalid/in_tready  | tuser kind; tdata code, row, column
//   out_     | out       | out_tvalid/out_tready| tdata cursor, flags, read character
//   cfg_     | in        | cfg_we               | cfg_index, cfg_wdata (no read-back)
//
// After reset the block sweeps the whole cell memory (MAX_ROWS * MAX_COLS cells,
// 12288 at the defaults) to zero, one cell per cycle, and takes no word meanwhile.
// One word is in work at a time. Each passes decode and then done; between them a
// put runs any scroll, then the store, a tab's quotient and next stop, or nothing for
// a newline; a read inside the size in use reads and waits for the data. A scroll
// copies rows up via the single memory port pair (read a cell, write it back).
// A new word is taken as soon as the sequencer is idle, even while the previous
// result still waits in the output register; the result of that word waits for it.
`timescale 1ns / 1ps
`default_nettype none

module text_console_cell_writer
  import tccw_pkg::*;
#(
  parameter int MAX_COLS = DEF_MAX_COLS,
  parameter int MAX_ROWS = DEF_MAX_ROWS
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   in_tvalid,
  output logic                        in_tready,
  input  wire logic [IN_TDATA_W-1:0]  in_tdata,   // [7:0] char_code, [14:8] read_row,
                                                  // [21:15] read_col, [23:22] zero
  input  wire logic                   in_tuser,   // [0] kind
  output logic                        out_tvalid,
  input  wire logic                   out_tready,
  output logic      [OUT_TDATA_W-1:0] out_tdata,  // [7:0] cursor_col, [14:8] cursor_row,
                                                  // [15] stored, [16] scrolled,
                                                  // [24:17] read_char, [31:25] zero
  input  wire logic                   cfg_we,
  input  wire logic [CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [CFG_DATA_W-1:0]  cfg_wdata
);

  localparam int DEPTH = MAX_ROWS * MAX_COLS;
  localparam int AW    = $clog2(DEPTH);

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_DECODE,
    S_SCROLL_RD,
    S_SCROLL_WR,
    S_BLANK,
    S_STORE,
    S_TAB_Q,
    S_TAB_N,
    S_RD,
    S_RD_WAIT,
    S_DONE
  } state_t;

  state_t state_r, state_nxt;

  logic [COL_W-1:0]      columns_r, columns_nxt;
  logic [ROW_W-1:0]      rows_r, rows_nxt;
  logic                  kind_r, kind_nxt;
  logic [CHAR_W-1:0]     code_r, code_nxt;
  logic [ROW_W-1:0]      rrow_r, rrow_nxt;
  logic [RCOL_W-1:0]     rcol_r, rcol_nxt;
  logic [COL_W-1:0]      col_r, col_nxt;
  logic [ROW_W-1:0]      line_r, line_nxt;
  logic [ROW_W-1:0]      sr_r, sr_nxt;
  logic [COL_W-1:0]      sc_r, sc_nxt;
  logic [AW-1:0]         clr_r, clr_nxt;
  logic [TAB_QUOT_W-1:0] quot_r, quot_nxt;
  logic                  stored_r, stored_nxt;
  logic                  scrolled_r, scrolled_nxt;
  logic [CHAR_W-1:0]     rchar_r, rchar_nxt;
  logic                  out_tvalid_r, out_tvalid_nxt;
  logic [OUT_TDATA_W-1:0] out_tdata_r, out_tdata_nxt;

  // Effective size: zero reads as one, anything past the store reads as its edge.
  logic [COL_W-1:0] nc;
  logic [ROW_W-1:0] nr;

  always_comb begin
    if (columns_r == '0) begin
      nc = COL_W'(1);
    end else if ({1'b0, columns_r} > (COL_W+1)'(MAX_COLS)) begin
      nc = COL_W'(MAX_COLS);
    end else begin
      nc = columns_r;
    end
    if (rows_r == '0) begin
      nr = ROW_W'(1);
    end else if ({2'b0, rows_r} > (ROW_W+2)'(MAX_ROWS)) begin
      nr = ROW_W'(MAX_ROWS);
    end else begin
      nr = rows_r;
    end
  end

  // Shared address unit: every memory access but the clearing sweep goes through row * MAX_COLS + column.
  logic [ROW_W-1:0] addr_row;
  logic [COL_W-1:0] addr_col;
  logic [AW-1:0]    cell_addr;
  logic             ram_we, ram_re;
  logic [CHAR_W-1:0] ram_wdata, ram_rdata;

  always_comb begin
    case (state_r)
      S_SCROLL_RD: begin
        addr_row = sr_r + ROW_W'(1);
        addr_col = sc_r;
      end
      S_SCROLL_WR: begin
        addr_row = sr_r;
        addr_col = sc_r;
      end
      S_BLANK: begin
        addr_row = nr - ROW_W'(1);
        addr_col = sc_r;
      end
      S_RD: begin
        addr_row = rrow_r;
        addr_col = {1'b0, rcol_r};
      end
      default: begin
        addr_row = line_r;
        addr_col = col_r;
      end
    endcase
    if (state_r == S_CLEAR) begin
      cell_addr = clr_r;
    end else begin
      cell_addr = AW'(AW'(addr_row) * AW'(MAX_COLS)) + AW'(addr_col);
    end
  end

  assign ram_we = (state_r == S_CLEAR) || (state_r == S_SCROLL_WR) ||
                  (state_r == S_BLANK) || (state_r == S_STORE);
  assign ram_re = (state_r == S_SCROLL_RD) || (state_r == S_RD);

  always_comb begin
    case (state_r)
      S_SCROLL_WR: ram_wdata = ram_rdata;
      S_STORE:     ram_wdata = code_r;
      default:     ram_wdata = '0;
    endcase
  end

  tccw_cell_ram #(
    .DEPTH (DEPTH),
    .AW    (AW),
    .DW    (CHAR_W)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (cell_addr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (cell_addr),
    .rdata (ram_rdata)
  );

  // Decode of the latched character.
  logic is_nl, is_tab;
  assign is_nl  = (code_r == CODE_LF) || (code_r == CODE_CR);
  assign is_tab = (code_r == CODE_TAB);

  // Where a put goes once any line feed or scroll is finished.
  state_t post_state;
  always_comb begin
    if (is_nl) begin
      post_state = S_DONE;
    end else if (is_tab) begin
      post_state = S_TAB_Q;
    end else begin
      post_state = S_STORE;
    end
  end

  logic [ROW_W-1:0]      pin_line;
  logic                  wrap;
  logic [2*COL_W-1:0]    tab_prod;
  logic [COL_W:0]        tab_next;

  assign pin_line = (line_r >= nr) ? (nr - ROW_W'(1)) : line_r;
  assign wrap     = is_nl || (col_r >= nc);
  assign tab_prod = (2*COL_W)'(col_r) * (2*COL_W)'(TAB_RECIP);
  assign tab_next = (COL_W+1)'(quot_r) * (COL_W+1)'(TAB_STOP) + (COL_W+1)'(TAB_STOP);

  always_comb begin
    state_nxt      = state_r;
    columns_nxt    = columns_r;
    rows_nxt       = rows_r;
    kind_nxt       = kind_r;
    code_nxt       = code_r;
    rrow_nxt       = rrow_r;
    rcol_nxt       = rcol_r;
    col_nxt        = col_r;
    line_nxt       = line_r;
    sr_nxt         = sr_r;
    sc_nxt         = sc_r;
    clr_nxt        = clr_r;
    quot_nxt       = quot_r;
    stored_nxt     = stored_r;
    scrolled_nxt   = scrolled_r;
    rchar_nxt      = rchar_r;
    out_tvalid_nxt = out_tvalid_r && !out_tready;
    out_tdata_nxt  = out_tdata_r;

    if (cfg_we) begin
      case (cfg_index)
        CFG_COLUMNS: columns_nxt = cfg_wdata[COL_W-1:0];
        CFG_ROWS:    rows_nxt    = cfg_wdata[ROW_W-1:0];
        default:     ;
      endcase
    end

    case (state_r)
      S_CLEAR: begin
        clr_nxt = clr_r + AW'(1);
        if (clr_r == AW'(DEPTH - 1)) begin
          state_nxt = S_IDLE;
        end
      end

      S_IDLE: begin
        if (in_tvalid) begin
          kind_nxt     = in_tuser;
          code_nxt     = in_tdata[IN_CODE_LSB +: CHAR_W];
          rrow_nxt     = in_tdata[IN_RROW_LSB +: ROW_W];
          rcol_nxt     = in_tdata[IN_RCOL_LSB +: RCOL_W];
          stored_nxt   = 1'b0;
          scrolled_nxt = 1'b0;
          rchar_nxt    = '0;
          state_nxt    = S_DECODE;
        end
      end

      S_DECODE: begin
        if (kind_r == KIND_READ) begin
          // Cells outside the configured size read as zero.
          if ((rrow_r < nr) && ({1'b0, rcol_r} < nc)) begin
            state_nxt = S_RD;
          end else begin
            state_nxt = S_DONE;
          end
        end else if (wrap) begin
          col_nxt = '0;
          if (({1'b0, pin_line} + (ROW_W+1)'(1)) >= {1'b0, nr}) begin
            line_nxt     = nr - ROW_W'(1);
            scrolled_nxt = 1'b1;
            sr_nxt       = '0;
            sc_nxt       = '0;
            state_nxt    = (nr == ROW_W'(1)) ? S_BLANK : S_SCROLL_RD;
          end else begin
            line_nxt  = pin_line + ROW_W'(1);
            state_nxt = post_state;
          end
        end else begin
          line_nxt  = pin_line;
          state_nxt = post_state;
        end
      end

      S_SCROLL_RD: begin
        state_nxt = S_SCROLL_WR;
      end

      S_SCROLL_WR: begin
        state_nxt = S_SCROLL_RD;
        if (sc_r == nc - COL_W'(1)) begin
          sc_nxt = '0;
          if (sr_r + ROW_W'(1) == nr - ROW_W'(1)) begin
            state_nxt = S_BLANK;
          end else begin
            sr_nxt = sr_r + ROW_W'(1);
          end
        end else begin
          sc_nxt = sc_r + COL_W'(1);
        end
      end

      S_BLANK: begin
        if (sc_r == nc - COL_W'(1)) begin
          sc_nxt    = '0;
          state_nxt = post_state;
        end else begin
          sc_nxt = sc_r + COL_W'(1);
        end
      end

      S_STORE: begin
        col_nxt    = col_r + COL_W'(1);
        stored_nxt = 1'b1;
        state_nxt  = S_DONE;
      end

      S_TAB_Q: begin
        quot_nxt  = tab_prod[TAB_RECIP_SH +: TAB_QUOT_W];
        state_nxt = S_TAB_N;
      end

      S_TAB_N: begin
        // Next multiple of the tab stop, held at the top of the column range.
        col_nxt   = tab_next[COL_W] ? {COL_W{1'b1}} : tab_next[COL_W-1:0];
        state_nxt = S_DONE;
      end

      S_RD: begin
        state_nxt = S_RD_WAIT;
      end

      S_RD_WAIT: begin
        rchar_nxt = ram_rdata;
        state_nxt = S_DONE;
      end

      S_DONE: begin
        if (!out_tvalid_r || out_tready) begin
          out_tvalid_nxt = 1'b1;
          out_tdata_nxt  = '0;
          out_tdata_nxt[OUT_COL_LSB +: COL_W]   = col_r;
          out_tdata_nxt[OUT_ROW_LSB +: ROW_W]   = line_r;
          out_tdata_nxt[OUT_STORED_BIT]         = stored_r;
          out_tdata_nxt[OUT_SCROLL_BIT]         = scrolled_r;
          out_tdata_nxt[OUT_CHAR_LSB +: CHAR_W] = rchar_r;
          state_nxt = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    kind_r      <= kind_nxt;
    code_r      <= code_nxt;
    rrow_r      <= rrow_nxt;
    rcol_r      <= rcol_nxt;
    sr_r        <= sr_nxt;
    sc_r        <= sc_nxt;
    quot_r      <= quot_nxt;
    stored_r    <= stored_nxt;
    scrolled_r  <= scrolled_nxt;
    rchar_r     <= rchar_nxt;
    out_tdata_r <= out_tdata_nxt;
    if (!rst_n) begin
      state_r      <= S_CLEAR;
      clr_r        <= '0;
      columns_r    <= COLUMNS_RST;
      rows_r       <= ROWS_RST;
      col_r        <= '0;
      line_r       <= '0;
      out_tvalid_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      clr_r        <= clr_nxt;
      columns_r    <= columns_nxt;
      rows_r       <= rows_nxt;
      col_r        <= col_nxt;
      line_r       <= line_nxt;
      out_tvalid_r <= out_tvalid_nxt;
    end
  end

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;

endmodule

`default_nettype wire

FILE: design/tccw_checker.sv
// Port-level checker for the text console cell writer, bound to the top level.
// Depends on tccw_pkg and text_console_cell_writer_assert.svh.
`timescale 1ns / 1ps
`default_nettype none
`include "text_console_cell_writer_assert.svh"

module tccw_checker
  import tccw_pkg::*;
(
  input wire logic                   clk,
  input wire logic                   rst_n,
  input wire logic                   in_tvalid,
  input wire logic                   in_tready,
  input wire logic                   out_tvalid,
  input wire logic                   out_tready,
  input wire logic [OUT_TDATA_W-1:0] out_tdata
);

  logic out_wait;
  logic in_take;
  logic store_shown;
  logic store_ok;

  assign out_wait    = out_tvalid && !out_tready;
  assign in_take     = in_tvalid && in_tready;
  assign store_shown = out_tvalid && out_tdata[OUT_STORED_BIT];
  assign store_ok    = (out_tdata[OUT_CHAR_LSB +: CHAR_W] == '0) &&
                       (out_tdata[OUT_COL_LSB +: COL_W] != '0);

  // A result that is not taken stays put.
  `TCCW_ASSERT_NEXT(a_out_hold, clk, rst_n, out_wait, out_tvalid && $stable(out_tdata))

  // The sequencer is busy in the cycle after it takes a word.
  `TCCW_ASSERT_NEXT(a_busy_after_accept, clk, rst_n, in_take, !in_tready)

  // A stored character never comes with read data, and leaves the cursor past column zero.
  `TCCW_ASSERT_NOW(a_store_fields, clk, rst_n, store_shown, store_ok)

  // Leaving reset starts the clearing sweep with nothing on offer.
  `TCCW_ASSERT_NOW(a_reset_exit, clk, rst_n, $rose(rst_n), !in_tready && !out_tvalid)

endmodule

bind text_console_cell_writer tccw_checker u_tccw_checker (.*);

`default_nettype wire

FILE: tb/tb_text_console_cell_writer.sv
// Self-checking testbench for text_console_cell_writer: a directed script, then random phases.
// Result words are predicted by a console model kept inside this file, except for rows with typed statuses.
// Depends on tccw_pkg and the RTL of the block only.
`timescale 1ns / 1ps

module tb_text_console_cell_writer;
  import tccw_pkg::*;

  // Most of the run time is the clearing sweep after reset and a handful of full-size
  // scrolls. The limit leaves a wide margin above the slowest plausible run.
  localparam int CYCLE_LIMIT  = 5_000_000;
  localparam int HALF_PERIOD  = 5;
  localparam int REPORT_LINES = 40;
  localparam int PHASES       = 17;

  // One input word as the block sees it, and one result word, field by field.
  typedef struct packed {
    logic              kind;
    logic [CHAR_W-1:0] code;
    logic [ROW_W-1:0]  row;
    logic [RCOL_W-1:0] col;
  } console_word_t;

  typedef struct packed {
    logic [COL_W-1:0]  cursor_col;
    logic [ROW_W-1:0]  cursor_row;
    logic              stored;
    logic              scrolled;
    logic [CHAR_W-1:0] read_char;
  } console_status_t;

  typedef enum logic {STEP_WORD, STEP_CFG} script_step_t;

  // One row of the directed script. It is either a word to send or a register write.
  // A row with typed set carries its expected status, written out by hand.
  typedef struct {
    script_step_t           step;
    console_word_t          word;
    logic [CFG_IDX_W-1:0]   reg_idx;
    int                     reg_val;
    bit                     typed;
    console_status_t        want;
  } script_row_t;

  logic                   clk        = 1'b0;
  logic                   rst_n      = 1'b0;
  logic                   in_tvalid  = 1'b0;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata   = '0;       // [7:0] char_code, [14:8] read_row,
                                                  // [21:15] read_col, [23:22] zero
  logic                   in_tuser   = KIND_PUT; // [0] kind
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;             // [7:0] cursor_col, [14:8] cursor_row,
                                                  // [15] stored, [16] scrolled,
                                                  // [24:17] read_char, [31:25] zero
  logic                   cfg_we     = 1'b0;
  logic [CFG_IDX_W-1:0]   cfg_index  = CFG_COLUMNS;
  logic [CFG_DATA_W-1:0]  cfg_wdata  = '0;

  text_console_cell_writer i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

  always #HALF_PERIOD clk = ~clk;

  // ---------------------------------------------------------------------------
  // Console model: cell store, cursor and the two size registers.
  // ---------------------------------------------------------------------------
  logic [CHAR_W-1:0] screen [DEF_MAX_ROWS][DEF_MAX_COLS];
  int unsigned       cur_col      = 0;
  int unsigned       cur_line     = 0;
  logic [COL_W-1:0]  columns_reg  = COLUMNS_RST;
  logic [ROW_W-1:0]  rows_reg     = ROWS_RST;
  bit                scrolled_now = 1'b0;
  int unsigned       scroll_total = 0;

  console_status_t   status_q[$];     // results still owed by the block, oldest first
  script_row_t       script[$];

  int                sender_idle_pct    = 0;
  int                receiver_stall_pct = 0;
  int                mismatches         = 0;
  int unsigned       cycle_count        = 0;
  int unsigned       results_seen       = 0;
  console_status_t   oldest;

  // Register values outside the legal range are clamped to it.
  function automatic int unsigned cols_in_use();
    if (columns_reg == 0) return 1;
    if (columns_reg > DEF_MAX_COLS) return DEF_MAX_COLS;
    return 32'(columns_reg);
  endfunction

  function automatic int unsigned rows_in_use();
    if (rows_reg == 0) return 1;
    if (rows_reg > DEF_MAX_ROWS) return DEF_MAX_ROWS;
    return 32'(rows_reg);
  endfunction

  // Move to column 0 of the next line. Running off the last row in use scrolls the
  // rows up by one and blanks the last row. Only the columns in use move; the cells
  // to their right keep whatever they held.
  function automatic void next_line();
    int unsigned nc;
    int unsigned nr;
    nc = cols_in_use();
    nr = rows_in_use();
    cur_col = 0;
    cur_line++;
    if (cur_line >= nr) begin
      for (int unsigned r = 0; r + 1 < nr; r++)
        for (int unsigned c = 0; c < nc; c++)
          screen[r][c] = screen[r + 1][c];
      for (int unsigned c = 0; c < nc; c++)
        screen[nr - 1][c] = '0;
      cur_line = nr - 1;
      scrolled_now = 1'b1;
      scroll_total++;
    end
  endfunction

  // Apply one accepted word to the model and return the status the block owes for it.
  function automatic console_status_t advance_console(console_word_t w);
    console_status_t s;
    int unsigned     nr;
    int unsigned     stop;
    s = '0;
    scrolled_now = 1'b0;
    if (w.kind == KIND_READ) begin
      // A read leaves the cursor alone. Outside the size in use it returns zero.
      if (w.row < rows_in_use() && w.col < cols_in_use())
        s.read_char = screen[w.row][w.col];
    end else begin
      // If the rows register shrank under the cursor, pin the cursor to the last row first.
      nr = rows_in_use();
      if (cur_line >= nr) cur_line = nr - 1;
      if (w.code == CODE_LF || w.code == CODE_CR) begin
        next_line();
      end else if (w.code == CODE_TAB) begin
        // A tab wraps only from past the last column. It may then step beyond the
        // columns in use, but never past 255.
        if (cur_col >= cols_in_use()) next_line();
        stop = cur_col + (TAB_STOP - cur_col % TAB_STOP);
        cur_col = (stop > 255) ? 255 : stop;
      end else begin
        // Every other byte is stored, the null byte included.
        if (cur_col >= cols_in_use()) next_line();
        screen[cur_line][cur_col] = w.code;
        cur_col++;
        s.stored = 1'b1;
      end
    end
    s.cursor_col = cur_col[COL_W-1:0];
    s.cursor_row = cur_line[ROW_W-1:0];
    s.scrolled   = scrolled_now;
    return s;
  endfunction

  // ---------------------------------------------------------------------------
  // Directed script helpers.
  // ---------------------------------------------------------------------------
  function automatic console_status_t status_of(int col, int row, bit st, bit sc, int ch);
    console_status_t s;
    s.cursor_col = col[COL_W-1:0];
    s.cursor_row = row[ROW_W-1:0];
    s.stored     = st;
    s.scrolled   = sc;
    s.read_char  = ch[CHAR_W-1:0];
    return s;
  endfunction

  function automatic void script_word(logic kind, int code, int row, int col,
                                      bit typed = 1'b0, console_status_t want = '0);
    script_row_t e;
    e.step      = STEP_WORD;
    e.word.kind = kind;
    e.word.code = code[CHAR_W-1:0];
    e.word.row  = row[ROW_W-1:0];
    e.word.col  = col[RCOL_W-1:0];
    e.reg_idx   = CFG_COLUMNS;
    e.reg_val   = 0;
    e.typed     = typed;
    e.want      = want;
    script.insert(script.size(), e);
  endfunction

  function automatic void script_cfg(logic [CFG_IDX_W-1:0] idx, int val);
    script_row_t e;
    e.step    = STEP_CFG;
    e.word    = '0;
    e.reg_idx = idx;
    e.reg_val = val;
    e.typed   = 1'b0;
    e.want    = '0;
    script.insert(script.size(), e);
  endfunction

  // ---------------------------------------------------------------------------
  // Input side. Words change at the falling edge. A word counts as accepted at the
  // rising edge where in_tvalid and in_tready are both high. The model runs at that
  // point, so its state always follows the order in which the block takes words.
  // ---------------------------------------------------------------------------
  task automatic send_word(input console_word_t w, input bit typed,
                           input console_status_t want);
    int unsigned            gap;
    logic [IN_TDATA_W-1:0]  payload;
    console_status_t        predicted;
    gap = 0;
    while (gap < 50 && $urandom_range(99) < sender_idle_pct) gap++;
    payload = '0;
    payload[IN_CODE_LSB +: CHAR_W] = w.code;
    payload[IN_RROW_LSB +: ROW_W]  = w.row;
    payload[IN_RCOL_LSB +: RCOL_W] = w.col;
    @(negedge clk);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= payload;
    in_tuser  <= w.kind;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    predicted = advance_console(w);
    status_q.insert(status_q.size(), typed ? want : predicted);
  endtask

  // Registers change only with the block idle. The input is released first, then
  // every owed result must arrive before the write.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int val);
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (status_q.size() != 0) @(negedge clk);
    repeat (6) @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val[CFG_DATA_W-1:0];
    @(negedge clk);
    cfg_we    <= 1'b0;
    if (idx == CFG_COLUMNS) columns_reg = val[COL_W-1:0];
    else rows_reg = val[ROW_W-1:0];
  endtask

  // Random traffic. Most reads land inside the size in use, so they see stored text.
  // The rest cover the whole 7-bit range of row and column. The code byte is random
  // on every word, and the mix of newlines and tabs is set by the caller.
  function automatic console_word_t random_word(int read_pct, int nl_pct, int tab_pct);
    console_word_t w;
    int unsigned   pick;
    w.code = CHAR_W'($urandom_range(255));
    w.row  = ROW_W'(($urandom_range(3) == 0) ? $urandom_range(127)
                                             : $urandom_range(rows_in_use() - 1));
    w.col  = RCOL_W'(($urandom_range(3) == 0) ? $urandom_range(127)
                                              : $urandom_range(cols_in_use() - 1));
    if ($urandom_range(99) < read_pct) begin
      w.kind = KIND_READ;
    end else begin
      w.kind = KIND_PUT;
      pick = $urandom_range(99);
      if (pick < nl_pct) w.code = $urandom_range(1) ? CODE_LF : CODE_CR;
      else if (pick < nl_pct + tab_pct) w.code = CODE_TAB;
    end
    return w;
  endfunction

  // One phase: set both registers, then send up to count words. A nonzero
  // scroll_stop ends the phase early, once that many scrolls have happened. This
  // keeps full-size scrolls, which are slow, down to a few.
  task automatic run_phase(input int cols, input int nrows, input int count,
                           input int read_pct, input int nl_pct, input int tab_pct,
                           input int scroll_stop);
    int unsigned scroll_mark;
    write_reg(CFG_COLUMNS, cols);
    write_reg(CFG_ROWS, nrows);
    scroll_mark = scroll_total;
    for (int n = 0; n < count; n++) begin
      if (scroll_stop != 0 && scroll_total >= scroll_mark + scroll_stop) break;
      send_word(random_word(read_pct, nl_pct, tab_pct), 1'b0, '0);
    end
  endtask

  // ---------------------------------------------------------------------------
  // Output side: the receiver stalls at random, and each accepted result word is
  // checked against the oldest owed status.
  // ---------------------------------------------------------------------------
  always @(negedge clk) out_tready <= ($urandom_range(99) >= receiver_stall_pct);

  task automatic report_mismatch(input string msg);
    mismatches++;
    if (mismatches <= REPORT_LINES)
      $display("cycle %0d, result %0d: %s", cycle_count, results_seen, msg);
  endtask

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      if (status_q.size() == 0) begin
        report_mismatch($sformatf("result word 0x%h arrived with nothing owed", out_tdata));
      end else begin
        oldest = status_q.pop_front();
        if (out_tdata[OUT_COL_LSB +: COL_W] !== oldest.cursor_col)
          report_mismatch($sformatf("cursor_col got %0d, want %0d",
                                    out_tdata[OUT_COL_LSB +: COL_W], oldest.cursor_col));
        if (out_tdata[OUT_ROW_LSB +: ROW_W] !== oldest.cursor_row)
          report_mismatch($sformatf("cursor_row got %0d, want %0d",
                                    out_tdata[OUT_ROW_LSB +: ROW_W], oldest.cursor_row));
        if (out_tdata[OUT_STORED_BIT] !== oldest.stored)
          report_mismatch($sformatf("stored got %b, want %b",
                                    out_tdata[OUT_STORED_BIT], oldest.stored));
        if (out_tdata[OUT_SCROLL_BIT] !== oldest.scrolled)
          report_mismatch($sformatf("scrolled got %b, want %b",
                                    out_tdata[OUT_SCROLL_BIT], oldest.scrolled));
        if (out_tdata[OUT_CHAR_LSB +: CHAR_W] !== oldest.read_char)
          report_mismatch($sformatf("read_char got 0x%h, want 0x%h",
                                    out_tdata[OUT_CHAR_LSB +: CHAR_W], oldest.read_char));
      end
      results_seen++;
    end
  end

  // A hang anywhere, including in the clearing sweep after reset, ends here.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Main sequence.
  // ---------------------------------------------------------------------------
  initial begin
    int ncols;
    int nrows;

    foreach (screen[r, c]) screen[r][c] = '0;

    // Directed script, starting at the reset sizes of 127 columns by 95 rows. The first
    // rows can be worked out by hand from a cleared store, so their statuses are typed in.
    script_word(KIND_READ, 8'h00, 0, 0, 1'b1, status_of(0, 0, 0, 0, 8'h00));
    script_word(KIND_PUT,  8'h41, 0, 0, 1'b1, status_of(1, 0, 1, 0, 8'h00));
    script_word(KIND_PUT,  8'h00, 0, 0, 1'b1, status_of(2, 0, 1, 0, 8'h00)); // null byte
    script_word(KIND_PUT,  8'hFF, 0, 0, 1'b1, status_of(3, 0, 1, 0, 8'h00));
    script_word(KIND_PUT,  CODE_TAB, 0, 0, 1'b1, status_of(5, 0, 0, 0, 8'h00));
    script_word(KIND_READ, 8'hFF, 0, 2, 1'b1, status_of(5, 0, 0, 0, 8'hFF));
    script_word(KIND_PUT,  CODE_LF, 0, 0, 1'b1, status_of(0, 1, 0, 0, 8'h00));
    script_word(KIND_PUT,  CODE_CR, 0, 0, 1'b1, status_of(0, 2, 0, 0, 8'h00));
    // Reads outside the size in use return zero.
    script_word(KIND_READ, 8'h00, 127, 127, 1'b1, status_of(0, 2, 0, 0, 8'h00));
    script_word(KIND_READ, 8'h00, 95, 126, 1'b1, status_of(0, 2, 0, 0, 8'h00));
    // Zero in both registers acts as one column by one row. The cursor on row 2 is
    // first pinned back to row 0. After that, every wrap scrolls, which only blanks row 0.
    script_cfg(CFG_COLUMNS, 0);
    script_cfg(CFG_ROWS, 0);
    script_word(KIND_PUT,  8'h78, 0, 0);
    script_word(KIND_PUT,  8'h79, 0, 0);
    script_word(KIND_PUT,  CODE_TAB, 0, 0);
    script_word(KIND_READ, 8'h00, 0, 0);
    // Oversized values clamp to the full store. The 0xFF in column 2 lay outside the
    // narrow scrolls, so it must still be there.
    script_cfg(CFG_COLUMNS, 255);
    script_cfg(CFG_ROWS, 127);
    script_word(KIND_READ, 8'h00, 0, 2);
    script_word(KIND_PUT,  CODE_TAB, 0, 0);
    script_cfg(CFG_COLUMNS, DEF_MAX_COLS);
    script_cfg(CFG_ROWS, DEF_MAX_ROWS);
    script_word(KIND_PUT,  CODE_LF, 0, 0);
    script_word(KIND_PUT,  8'h80, 0, 0);
    script_word(KIND_READ, 8'h00, 1, 0);
    // Smallest legal sizes. The cursor on row 1 makes the next wrap scroll.
    script_cfg(CFG_COLUMNS, 1);
    script_cfg(CFG_ROWS, 2);
    script_word(KIND_PUT,  8'h61, 0, 0);
    script_word(KIND_PUT,  CODE_CR, 0, 0);
    script_word(KIND_READ, 8'h00, 0, 0);

    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // The block clears its store after reset and takes no word until it is done.
    // The first handshake simply waits for that.
    foreach (script[i]) begin
      if (script[i].step == STEP_CFG) write_reg(script[i].reg_idx, script[i].reg_val);
      else send_word(script[i].word, script[i].typed, script[i].want);
    end

    // Random phases. The idling style rotates through four modes: none, a mostly idle
    // sender, a mostly stalling receiver, and light idling on both sides.
    for (int p = 0; p < PHASES; p++) begin
      case (p % 4)
        0: begin sender_idle_pct = 0;  receiver_stall_pct = 0;  end
        1: begin sender_idle_pct = 80; receiver_stall_pct = 0;  end
        2: begin sender_idle_pct = 0;  receiver_stall_pct = 80; end
        default: begin sender_idle_pct = 25; receiver_stall_pct = 25; end
      endcase
      case (p)
        // Full size and mostly newlines, stopped after two full-size scrolls.
        0: run_phase(DEF_MAX_COLS, DEF_MAX_ROWS, 400, 10, 80, 5, 2);
        // Oversized register values with the cursor on the last row. Mostly reads,
        // and the puts carry no deliberate newline or tab.
        1: run_phase(255, 127, 60, 70, 0, 0, 0);
        // Both registers zero. The cursor far below the single row gets pinned.
        2: run_phase(0, 0, 80, 30, 15, 15, 0);
        3: run_phase(1, 2, 100, 25, 10, 10, 0);
        default: begin
          // Mostly small screens, where scrolls are cheap, and now and then a wide
          // one with few rows.
          if ($urandom_range(3) == 0) begin
            ncols = $urandom_range(25, DEF_MAX_COLS);
            nrows = $urandom_range(2, 4);
          end else begin
            ncols = $urandom_range(1, 24);
            nrows = $urandom_range(2, 12);
          end
          run_phase(ncols, nrows, 100, 25, 10, 8, 0);
        end
      endcase
    end

    @(negedge clk);
    in_tvalid <= 1'b0;
    while (status_q.size() != 0) @(posedge clk);
    // Give a stray extra result word time to show up.
    repeat (30) @(posedge clk);
    if (mismatches == 0) $display("PASS");
    else $display("FAIL");
    $finish;
  end

endmodule
